FILE: hdl/tise_pkg.sv
// Shared types and constants for the tagged integer stream encoder.
// Holds beat structs, command codes, tag codes and the size table.
// No dependencies.
`default_nettype none
package tise_pkg;

    // command codes
    localparam logic [2:0] CMD_UINT  = 3'd0;
    localparam logic [2:0] CMD_SINT  = 3'd1;
    localparam logic [2:0] CMD_BOOL  = 3'd2;
    localparam logic [2:0] CMD_ARRAY = 3'd3;
    localparam logic [2:0] CMD_VAR   = 3'd4;
    localparam logic [2:0] CMD_RAW   = 3'd5;

    // tag codes
    localparam logic [7:0] TAG_ZERO   = 8'd0;
    localparam logic [7:0] TAG_ONE    = 8'd1;
    localparam logic [7:0] TAG_NEGONE = 8'd2;
    localparam logic [7:0] TAG_FALSE  = 8'd4;
    localparam logic [7:0] TAG_TRUE   = 8'd5;
    localparam logic [7:0] TAG_U8     = 8'd6;
    localparam logic [7:0] TAG_I8     = 8'd7;
    localparam logic [7:0] TAG_ARRAY8 = 8'd18;
    localparam logic [7:0] TAG_VAR8   = 8'd21;

    localparam int unsigned MAX_BYTES = 9;
    localparam int unsigned LEFT_W    = $clog2(MAX_BYTES + 1);

    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_beat;

    // one encoded record: tag, payload and number of bytes still to send
    typedef struct packed {
        logic [7:0]        tag;
        logic [63:0]       payload;
        logic [LEFT_W-1:0] left;
    } t_record;

    // payload bytes for size classes 0..5
    function automatic logic [LEFT_W-1:0] class_bytes(input logic [2:0] k);
        logic [LEFT_W-1:0] nb;
        case (k)
            3'd0:    nb = LEFT_W'(1);
            3'd1:    nb = LEFT_W'(2);
            3'd2:    nb = LEFT_W'(3);
            3'd3:    nb = LEFT_W'(4);
            3'd4:    nb = LEFT_W'(5);
            default: nb = LEFT_W'(8);
        endcase
        return nb;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/tise_encode.sv
// Combinational encoder: turns one command beat into a tagged record.
// Depends on tise_pkg.
`default_nettype none
module tise_encode import tise_pkg::*; (
    input  wire t_in_beat i_beat,
    output t_record       o_rec,
    output logic          o_keep
);

    logic [63:0] v;
    logic        neg;
    logic [63:0] mag;
    logic [2:0]  uk;
    logic [2:0]  sk;
    logic [31:0] len;

    assign v   = i_beat.value;
    assign neg = v[63];
    assign mag = neg ? (64'd0 - v) : v;
    assign len = v[31:0];

    always_comb begin
        if (v[63:8] == '0)       uk = 3'd0;
        else if (v[63:16] == '0) uk = 3'd1;
        else if (v[63:24] == '0) uk = 3'd2;
        else if (v[63:32] == '0) uk = 3'd3;
        else if (v[63:40] == '0) uk = 3'd4;
        else                     uk = 3'd5;
    end

    always_comb begin
        if (mag[63:7] == '0)       sk = 3'd0;
        else if (mag[63:15] == '0) sk = 3'd1;
        else if (mag[63:23] == '0) sk = 3'd2;
        else if (mag[63:31] == '0) sk = 3'd3;
        else if (mag[63:39] == '0) sk = 3'd4;
        else                       sk = 3'd5;
    end

    always_comb begin
        o_rec.tag     = TAG_ZERO;
        o_rec.payload = v;
        o_rec.left    = LEFT_W'(1);
        o_keep        = 1'b1;
        case (i_beat.command)
            CMD_UINT: begin
                if (v == 64'd0) begin
                    o_rec.tag = TAG_ZERO;
                end else if (v == 64'd1) begin
                    o_rec.tag = TAG_ONE;
                end else begin
                    o_rec.tag  = TAG_U8 + {4'd0, uk, 1'b0};
                    o_rec.left = class_bytes(uk) + LEFT_W'(1);
                end
            end
            CMD_SINT: begin
                if (v == 64'd0) begin
                    o_rec.tag = TAG_ZERO;
                end else if (v == 64'd1) begin
                    o_rec.tag = TAG_ONE;
                end else if (v == '1) begin
                    o_rec.tag = TAG_NEGONE;
                end else begin
                    o_rec.tag  = TAG_I8 + {4'd0, sk, 1'b0};
                    o_rec.left = class_bytes(sk) + LEFT_W'(1);
                end
            end
            CMD_BOOL: begin
                o_rec.tag = v[0] ? TAG_TRUE : TAG_FALSE;
            end
            CMD_ARRAY, CMD_VAR: begin
                o_rec.tag = (i_beat.command == CMD_ARRAY) ? TAG_ARRAY8 : TAG_VAR8;
                if (len[31:8] == '0) begin
                    o_rec.left = LEFT_W'(2);
                end else if (len[31:16] == '0) begin
                    o_rec.tag  = o_rec.tag + 8'd1;
                    o_rec.left = LEFT_W'(3);
                end else begin
                    o_rec.tag  = o_rec.tag + 8'd2;
                    o_rec.left = LEFT_W'(5);
                end
            end
            CMD_RAW: begin
                o_rec.tag = v[7:0];
            end
            default: begin
                o_keep = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hdl/tise_serializer.sv
// Result register and byte shifter: sends a record one beat per cycle while the output is not stalled.
// Depends on tise_pkg.
`default_nettype none
module tise_serializer import tise_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_load,
    input  wire t_record i_rec,
    output logic        o_free,
    output logic        o_valid,
    output t_out_beat   o_beat,
    input  wire         i_stall
);

    logic              r_valid;
    logic [71:0]       r_bytes;
    logic [LEFT_W-1:0] r_left;
    logic              fire;

    assign fire    = r_valid && !i_stall;
    assign o_free  = !r_valid || (fire && r_left == LEFT_W'(1));
    assign o_valid = r_valid;
    assign o_beat.out_byte = r_bytes[7:0];
    assign o_beat.last     = (r_left == LEFT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free) begin
            r_bytes <= {i_rec.payload, i_rec.tag};
            r_left  <= i_rec.left;
        end else if (fire) begin
            // advance to the next byte of the record
            r_bytes <= {8'd0, r_bytes[71:8]};
            r_left  <= r_left - LEFT_W'(1);
        end
    end

endmodule
`default_nettype wire

FILE: hdl/tagged_integer_stream_encoder.sv
// Top level of the tagged integer stream encoder: input register, encoder
// and byte serializer. Depends on tise_pkg, tise_encode, tise_serializer.
//
//  channel | direction | handshake               | beat
//  in      | input     | i_in_valid / o_in_stall | t_in_beat  (command, value)
//  out     | output    | o_out_valid / i_out_stall | t_out_beat (out_byte, last)
//
// An input beat is registered, encoded in the next cycle and loaded into the
// result register, which sends 1 to 9 bytes, one per cycle while the output is
// not stalled. An accepted beat passes the input register and the result
// register before its first byte appears. Unused commands give no bytes.
// Reset (synchronous, active low) empties both registers. A stalled output
// holds its byte; the input stalls only while its register is full and the
// result register cannot take the next record.
`default_nettype none
module tagged_integer_stream_encoder import tise_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_in_valid,
    output logic      o_in_stall,
    input  wire t_in_beat i_in_data,
    output logic      o_out_valid,
    input  wire       i_out_stall,
    output t_out_beat o_out_data
);

    logic     r_in_valid;
    t_in_beat r_in;
    t_record  enc_rec;
    logic     enc_keep;
    logic     ser_free;
    logic     take;
    logic     in_fire;

    // drop unused commands at once, otherwise wait for the serializer
    assign take       = r_in_valid && (!enc_keep || ser_free);
    assign o_in_stall = r_in_valid && !take;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in_data;
        end
    end

    tise_encode u_encode (
        .i_beat (r_in),
        .o_rec  (enc_rec),
        .o_keep (enc_keep)
    );

    tise_serializer u_serializer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (r_in_valid && enc_keep),
        .i_rec   (enc_rec),
        .o_free  (ser_free),
        .o_valid (o_out_valid),
        .o_beat  (o_out_data),
        .i_stall (i_out_stall)
    );

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted input beat not held");

    a_record_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_data.last) |=> o_out_valid)
        else $error("record cut short before its last byte");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && o_out_valid))
        else $error("input stalled with nothing pending");

endmodule
`default_nettype wire

FILE: tb/tagged_integer_stream_encoder_test.sv
// Self-checking testbench for tagged_integer_stream_encoder: a directed table, then random
// commands, with bursty input traffic and output stalls; each byte is checked against the table or a predictor.
// Depends on tise_pkg and the encoder RTL.
module tagged_integer_stream_encoder_test;
    import tise_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [7:0] TAG_U64      = TAG_U8 + 8'd10;
    localparam logic [7:0] TAG_I64      = TAG_I8 + 8'd10;
    localparam int         RANDOM_ITEMS = 200;
    localparam int         IDLE_LIMIT   = 3000;
    localparam int         TAIL_CYCLES  = 20;

    typedef enum int {STALL_NONE, STALL_SOME, STALL_BEAT, STALL_MOST} t_stall_mode;

    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] value;
        bit          typed;
        int          nres;
        logic [7:0]  tag;
        logic [63:0] payload;
    } t_script_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    t_out_beat encoded_bytes[$];
    int        mismatches = 0;
    int        items_sent = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;
    int        stall_left = 0;
    int        stall_phase = 0;
    t_stall_mode stall_mode = STALL_NONE;
    bit        held_stalled = 1'b0;
    t_out_beat held_beat;

    // typed rows carry the record straight from the format; the rest go to the predictor
    t_script_row script [0:24] = '{
        '{CMD_UINT,  64'd0,                  1'b1, 1, TAG_ZERO,   64'd0},
        '{CMD_UINT,  64'd1,                  1'b1, 1, TAG_ONE,    64'd0},
        '{CMD_UINT,  64'd255,                1'b1, 2, TAG_U8,     64'd255},
        '{CMD_UINT,  64'd256,                1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_UINT,  64'd65536,              1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_UINT,  64'h1_0000_0000,        1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_UINT,  64'h100_0000_0000,      1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_UINT,  '1,                     1'b1, 9, TAG_U64,    '1},
        '{CMD_SINT,  64'd0,                  1'b1, 1, TAG_ZERO,   64'd0},
        '{CMD_SINT,  64'd1,                  1'b1, 1, TAG_ONE,    64'd0},
        '{CMD_SINT,  '1,                     1'b1, 1, TAG_NEGONE, 64'd0},
        '{CMD_SINT,  64'd127,                1'b1, 2, TAG_I8,     64'd127},
        '{CMD_SINT,  -64'sd128,              1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_SINT,  64'h8000_0000_0000_0000, 1'b1, 9, TAG_I64,
          64'h8000_0000_0000_0000},
        '{CMD_SINT,  64'h7fff_ffff_ffff_ffff, 1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_BOOL,  64'd0,                  1'b1, 1, TAG_FALSE,  64'd0},
        '{CMD_BOOL,  '1,                     1'b1, 1, TAG_TRUE,   64'd0},
        '{CMD_BOOL,  64'd2,                  1'b1, 1, TAG_FALSE,  64'd0},
        '{CMD_ARRAY, 64'd0,                  1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_ARRAY, 64'd65535,              1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_ARRAY, 64'h1_0000_0005,        1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_VAR,   64'hffff_ffff,          1'b0, 0, TAG_ZERO,   64'd0},
        '{CMD_RAW,   64'h1234_5678_9abc_defe, 1'b1, 1, 8'hfe,     64'd0},
        '{CMD_SPARE_LO, '1,                  1'b1, 0, TAG_ZERO,   64'd0},
        '{CMD_SPARE_HI, 64'd1,               1'b1, 0, TAG_ZERO,   64'd0}
    };

    tagged_integer_stream_encoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // tag, payload and total byte count of the record for one command
    function automatic void encode_item(input logic [2:0] cmd, input logic [63:0] v,
                                        output logic [7:0] tag, output logic [63:0] payload,
                                        output int nres);
        logic [63:0] mag;
        int k;
        tag = TAG_ZERO;
        payload = v;
        nres = 0;
        k = 0;
        case (cmd)
            CMD_UINT: begin
                nres = 1;
                if (v == 64'd0) begin
                    tag = TAG_ZERO;
                end else if (v == 64'd1) begin
                    tag = TAG_ONE;
                end else begin
                    while (k < 5 && v >= (64'd1 << (8 * k + 8))) k++;
                    tag = TAG_U8 + 8'(2 * k);
                    nres = 1 + ((k == 5) ? 8 : k + 1);
                end
            end
            CMD_SINT: begin
                mag = v[63] ? -v : v;
                nres = 1;
                if (v == 64'd0) begin
                    tag = TAG_ZERO;
                end else if (v == 64'd1) begin
                    tag = TAG_ONE;
                end else if (v == '1) begin
                    tag = TAG_NEGONE;
                end else begin
                    // magnitude picks the size, so the most negative value lands in 8 bytes
                    while (k < 5 && mag >= (64'd1 << (8 * k + 7))) k++;
                    tag = TAG_I8 + 8'(2 * k);
                    nres = 1 + ((k == 5) ? 8 : k + 1);
                end
            end
            CMD_BOOL: begin
                tag = v[0] ? TAG_TRUE : TAG_FALSE;
                nres = 1;
            end
            CMD_ARRAY, CMD_VAR: begin
                payload = {32'd0, v[31:0]};
                tag = (cmd == CMD_ARRAY) ? TAG_ARRAY8 : TAG_VAR8;
                if (payload < 64'd256) begin
                    nres = 2;
                end else if (payload < 64'd65536) begin
                    tag = tag + 8'd1;
                    nres = 3;
                end else begin
                    tag = tag + 8'd2;
                    nres = 5;
                end
            end
            CMD_RAW: begin
                tag = v[7:0];
                nres = 1;
            end
            default: nres = 0;
        endcase
    endfunction

    function automatic void expect_record(input logic [7:0] tag, input logic [63:0] payload,
                                          input int nres);
        t_out_beat b;
        int i;
        for (i = 0; i < nres; i++) begin
            b.out_byte = (i == 0) ? tag : payload[8 * (i - 1) +: 8];
            b.last = (i == nres - 1);
            encoded_bytes.push_back(b);
        end
    endfunction

    // enter and leave at a falling edge; a new burst starts after a random gap
    task automatic send_item(input logic [2:0] cmd, input logic [63:0] val,
                             input logic [7:0] tag, input logic [63:0] payload, input int nres);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 15);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                i_in_data <= t_in_beat'{command: 3'($urandom), value: rand64()};
                repeat (gap) @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data <= t_in_beat'{command: cmd, value: val};
        do @(posedge i_clk); while (o_in_stall);
        expect_record(tag, payload, nres);
        if (nres != 0) items_sent++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic send_predicted(input logic [2:0] cmd, input logic [63:0] val);
        logic [7:0] tag;
        logic [63:0] payload;
        int nres;
        encode_item(cmd, val, tag, payload, nres);
        send_item(cmd, val, tag, payload, nres);
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 150);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            STALL_NONE: i_out_stall <= 1'b0;
            STALL_SOME: i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_BEAT: i_out_stall <= (stall_phase % 5 < 2);
            default:    i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // a stalled beat must hold
            if (held_stalled && (!o_out_valid || o_out_data != held_beat)) begin
                $display("%0t: stalled beat changed, expected %02h/%0b got valid %0b %02h/%0b",
                         $time, held_beat.out_byte, held_beat.last, o_out_valid,
                         o_out_data.out_byte, o_out_data.last);
                mismatches++;
            end
            held_stalled = o_out_valid && i_out_stall;
            held_beat = o_out_data;
            if (o_out_valid && !i_out_stall) begin
                if (encoded_bytes.size() == 0) begin
                    $display("%0t: unexpected beat, expected none got %02h/%0b",
                             $time, o_out_data.out_byte, o_out_data.last);
                    mismatches++;
                end else begin
                    if (o_out_data.out_byte !== encoded_bytes[0].out_byte) begin
                        $display("%0t: out_byte expected %02h got %02h", $time,
                                 encoded_bytes[0].out_byte, o_out_data.out_byte);
                        mismatches++;
                    end
                    if (o_out_data.last !== encoded_bytes[0].last) begin
                        $display("%0t: last expected %0b got %0b", $time,
                                 encoded_bytes[0].last, o_out_data.last);
                        mismatches++;
                    end
                    void'(encoded_bytes.pop_front());
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] v;
        logic [63:0] tmp;
        logic [31:0] len;
        logic [2:0] hdr;
        int r;
        int sh;
        int k;
        int style;
        int n;
        int row;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (row = 0; row < 25; row++) begin
            if (script[row].typed)
                send_item(script[row].cmd, script[row].value, script[row].tag,
                          script[row].payload, script[row].nres);
            else
                send_predicted(script[row].cmd, script[row].value);
        end

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            sh = $urandom_range(0, 63);
            k = $urandom_range(1, 5);
            style = $urandom_range(0, 3);
            tmp = rand64();
            if (r < 22) begin
                case (style)
                    0: v = tmp >> sh;
                    1: v = (64'd1 << (8 * k)) - 64'($urandom_range(0, 1));
                    2: v = 64'($urandom_range(0, 3));
                    default: v = tmp;
                endcase
                send_predicted(CMD_UINT, v);
            end else if (r < 44) begin
                case (style)
                    0: v = tmp >> sh;
                    1: v = (64'd1 << (8 * k - 1)) - 64'($urandom_range(0, 1));
                    2: v = 64'($urandom_range(0, 2));
                    default: v = tmp;
                endcase
                if ($urandom_range(0, 1) == 1) v = -v;
                send_predicted(CMD_SINT, v);
            end else if (r < 52) begin
                send_predicted(CMD_BOOL, tmp);
            end else if (r < 70) begin
                hdr = (r < 61) ? CMD_ARRAY : CMD_VAR;
                n = 0;
                case (style)
                    0: len = tmp[31:0];
                    1: begin
                        case ($urandom_range(0, 2))
                            0: len = 32'd256 - 32'($urandom_range(0, 1));
                            1: len = 32'd65536 - 32'($urandom_range(0, 1));
                            default: len = '1;
                        endcase
                    end
                    2: begin
                        n = $urandom_range(0, 6);
                        len = 32'(n);
                    end
                    default: len = tmp[31:0] >> sh[4:0];
                endcase
                send_predicted(hdr, {tmp[63:32], len});
                // in the short-length style the header is followed by its payload as raw beats
                repeat (n) send_predicted(CMD_RAW, rand64());
            end else if (r < 96) begin
                send_predicted(CMD_RAW, tmp);
            end else begin
                send_predicted(($urandom_range(0, 1) == 1) ? CMD_SPARE_HI : CMD_SPARE_LO, tmp);
            end
        end
        i_in_valid <= 1'b0;

        while (encoded_bytes.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: sim.f
hdl/tise_pkg.sv
hdl/tise_encode.sv
hdl/tise_serializer.sv
hdl/tagged_integer_stream_encoder.sv
tb/tagged_integer_stream_encoder_test.sv
